/* src/insertion_sorter_macros.svh */
// ----------------------------------------------------------------------------
// Insertion sorter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

// Same-cycle implication.
`define ISORT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ISORT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/isort_pkg.sv */
// ----------------------------------------------------------------------------
// Insertion sorter package
// Sizes, status codes and controller state encoding.
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  localparam logic STATUS_SORTED = 1'b0;
  localparam logic STATUS_FULL   = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_CMP     = 5'b00010,
    ST_PLACE   = 5'b00100,
    ST_EMIT_RD = 5'b01000,
    ST_EMIT_WT = 5'b10000
  } state_e;

endpackage

/* src/isort_in_if.sv */
// ----------------------------------------------------------------------------
// Insertion sorter input channel
// Valid/ready channel carrying one value and its close-set mark.
// ----------------------------------------------------------------------------
interface isort_in_if import isort_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      close_set;

  modport source (output valid, output sample_value, output close_set, input ready);
  modport sink   (input valid, input sample_value, input close_set, output ready);

endinterface

/* src/isort_out_if.sv */
// ----------------------------------------------------------------------------
// Insertion sorter output channel
// Valid/ready channel carrying one sorted value or a full status.
// ----------------------------------------------------------------------------
interface isort_out_if import isort_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sorted_value;
  logic                      status;
  logic                      run_end;

  modport source (output valid, output sorted_value, output status, output run_end,
                  input ready);
  modport sink   (input valid, input sorted_value, input status, input run_end,
                  output ready);

endinterface

/* src/isort_ram.sv */
// ----------------------------------------------------------------------------
// Insertion sorter RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module isort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/insertion_sorter.sv */
// Insert: direct into an empty store, else larger entries move up one place first.
// Close: after the insert, each value is emitted by a RAM read, then an output load.
// Full-store insert without close: a status result, loaded in the accepting cycle.
// One request in flight at a time; the single RAM port pair sets the pace.
// Reset (rst_ni low, asynchronous) empties the store; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Insertion sorter
// Keeps values ordered in a RAM as they arrive and streams them out on close.
// ----------------------------------------------------------------------------
`include "insertion_sorter_macros.svh"

module insertion_sorter import isort_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  isort_in_if.sink    sample_i,
  isort_out_if.source result_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [ADDR_W-1:0]  k_q, k_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic               close_q, close_d;

  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic               out_status_q, out_status_d;
  logic               out_end_q, out_end_d;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [VALUE_W-1:0] wdata;
  logic               re;
  logic [ADDR_W-1:0]  raddr;
  logic [VALUE_W-1:0] rdata;

  logic               out_free;
  logic               accept;
  logic               full;
  logic               last;
  logic [CNT_W-1:0]   fill_m1;
  logic [CNT_W-1:0]   pos_m1;
  logic [CNT_W-1:0]   pos_m2;
  logic [CNT_W-1:0]   k_p1;

  isort_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free       = !out_valid_q || result_o.ready;
  assign sample_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept         = sample_i.valid && sample_i.ready;
  assign full           = fill_q == CNT_W'(DEPTH);
  assign fill_m1        = fill_q - CNT_W'(1);
  assign pos_m1         = pos_q - CNT_W'(1);
  assign pos_m2         = pos_q - CNT_W'(2);
  assign k_p1           = CNT_W'(k_q) + CNT_W'(1);
  assign last           = k_p1 == fill_q;

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    pos_d        = pos_q;
    k_d          = k_q;
    val_d        = val_q;
    close_d      = close_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_end_d    = out_end_q;
    we           = 1'b0;
    waddr        = pos_q[ADDR_W-1:0];
    wdata        = val_q;
    re           = 1'b0;
    raddr        = pos_m1[ADDR_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d   = sample_i.sample_value;
          close_d = sample_i.close_set;
          k_d     = '0;
          if (full) begin
            if (sample_i.close_set) begin
              state_d = ST_EMIT_RD;
            end else begin
              out_valid_d  = 1'b1;
              out_value_d  = '0;
              out_status_d = STATUS_FULL;
              out_end_d    = 1'b0;
            end
          end else if (fill_q == '0) begin
            we     = 1'b1;
            waddr  = '0;
            wdata  = sample_i.sample_value;
            fill_d = fill_q + CNT_W'(1);
            if (sample_i.close_set) begin
              state_d = ST_EMIT_RD;
            end
          end else begin
            re      = 1'b1;
            raddr   = fill_m1[ADDR_W-1:0];
            pos_d   = fill_q;
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        we = 1'b1;
        if ($signed(rdata) > $signed(val_q)) begin
          wdata = rdata;
          pos_d = pos_m1;
          if (pos_q == CNT_W'(1)) begin
            state_d = ST_PLACE;
          end else begin
            re    = 1'b1;
            raddr = pos_m2[ADDR_W-1:0];
          end
        end else begin
          fill_d  = fill_q + CNT_W'(1);
          state_d = close_q ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_PLACE: begin
        we      = 1'b1;
        waddr   = '0;
        fill_d  = fill_q + CNT_W'(1);
        state_d = close_q ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        re      = 1'b1;
        raddr   = k_q;
        state_d = ST_EMIT_WT;
      end
      ST_EMIT_WT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = rdata;
          out_status_d = STATUS_SORTED;
          out_end_d    = last;
          if (last) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_p1[ADDR_W-1:0];
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    k_q          <= k_d;
    val_q        <= val_d;
    close_q      <= close_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_end_q    <= out_end_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.sorted_value = out_value_q;
  assign result_o.status       = out_status_q;
  assign result_o.run_end      = out_end_q;

  `ISORT_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CNT_W'(DEPTH), "fill count above depth")
  `ISORT_ASSERT_IMP(a_full_result, out_valid_q && (out_status_q == STATUS_FULL),
                    (out_value_q == '0) && !out_end_q, "full status with payload")
  `ISORT_ASSERT_IMP(a_cmp_pos, state_q == ST_CMP, pos_q != '0, "compare at position zero")
  `ISORT_ASSERT_NXT(a_full_drop, accept && full && !sample_i.close_set,
                    out_valid_q && (fill_q == CNT_W'(DEPTH)), "full insert not reported")

endmodule

/* verif/insertion_sorter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Insertion sorter testbench
// Sends value sets with random gaps and receiver stalls, predicts each sorted
// run and full-status result, and checks every result in arrival order.
// ----------------------------------------------------------------------------
module insertion_sorter_tb import isort_pkg::*; ();

  localparam int unsigned RANDOM_ITEMS    = 300;
  localparam int unsigned DIRECTED_ITEMS  = DEPTH + 3;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 4 * DEPTH + 20;
  localparam int unsigned SHOWN_FAILURES  = 10;

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam value_t MIN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam value_t MAX_VALUE = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    value_t value;
    logic   status;
    logic   run_end;
  } sort_result_t;

  class sort_scoreboard;
    value_t       held_values[$];
    sort_result_t predicted_outputs[$];
    int unsigned  failures;
    int unsigned  results_checked;

    function void note_failure(string msg);
      if (failures < SHOWN_FAILURES) $display("ERROR: %s", msg);
      failures++;
    endfunction

    function void note_request(value_t v, logic close);
      int unsigned  pos;
      bit           full;
      sort_result_t res;
      full = held_values.size() >= DEPTH;
      if (!full) begin
        pos = held_values.size();
        while (pos > 0 && held_values[pos-1] > v) pos--;
        held_values.insert(pos, v);
      end
      if (!close) begin
        if (full) begin
          res.value   = '0;
          res.status  = STATUS_FULL;
          res.run_end = 1'b0;
          predicted_outputs.push_back(res);
        end
        return;
      end
      foreach (held_values[k]) begin
        res.value   = held_values[k];
        res.status  = STATUS_SORTED;
        res.run_end = (k == held_values.size() - 1);
        predicted_outputs.push_back(res);
      end
      held_values.delete();
    endfunction

    function void check_result(value_t v, logic status, logic run_end);
      sort_result_t exp_res;
      results_checked++;
      if (predicted_outputs.size() == 0) begin
        note_failure($sformatf("unexpected result: value %0d status %0b run_end %0b",
                               v, status, run_end));
        return;
      end
      exp_res = predicted_outputs.pop_front();
      if (exp_res.value !== v || exp_res.status !== status || exp_res.run_end !== run_end)
        note_failure($sformatf({"result mismatch: expected value %0d status %0b run_end %0b,",
                                " got value %0d status %0b run_end %0b"},
                               exp_res.value, exp_res.status, exp_res.run_end,
                               v, status, run_end));
    endfunction

    function int unsigned pending();
      return predicted_outputs.size();
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni = 1'b0;
  sort_scoreboard sb;
  bit             no_idle = 1'b0;
  bit             pressure_done = 1'b0;
  int unsigned    items_sent = 0;
  int unsigned    idle_cycles = 0;

  isort_in_if  sample_if ();
  isort_out_if result_if ();

  insertion_sorter i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic value_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return value_t'($urandom);
    if (r < 80) return value_t'(int'($urandom_range(0, 15)) - 8);
    if (r < 90) begin
      case ($urandom_range(0, 3))
        0:       return MIN_VALUE;
        1:       return MAX_VALUE;
        2:       return '0;
        default: return '1;
      endcase
    end
    if ($urandom_range(0, 1) == 1) return MIN_VALUE + value_t'($urandom_range(0, 3));
    return MAX_VALUE - value_t'($urandom_range(0, 3));
  endfunction

  task automatic send_request(value_t v, logic close);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_if.valid        <= 1'b1;
    sample_if.sample_value <= v;
    sample_if.close_set    <= close;
    do @(posedge clk_i); while (sample_if.ready !== 1'b1);
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if (sample_if.valid && sample_if.ready)
        sb.note_request(sample_if.sample_value, sample_if.close_set);
      if (result_if.valid && result_if.ready)
        sb.check_result(result_if.sorted_value, result_if.status, result_if.run_end);
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // hold off the receiver once for a long stretch so the block backs up
  initial begin
    int unsigned stall_left;
    stall_left      = 0;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!pressure_done && sb.results_checked >= 40) begin
        pressure_done = 1'b1;
        stall_left    = PRESSURE_CYCLES;
      end
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned r;
    int unsigned set_len;
    sb = new();
    sample_if.valid        = 1'b0;
    sample_if.sample_value = '0;
    sample_if.close_set    = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-value set, then a full store with extremes and duplicates
    send_request(MIN_VALUE, 1'b1);
    send_request(MAX_VALUE, 1'b0);
    send_request('0, 1'b0);
    send_request('1, 1'b0);
    send_request(MIN_VALUE, 1'b0);
    send_request(value_t'(1), 1'b0);
    send_request(value_t'(5), 1'b0);
    send_request(value_t'(5), 1'b0);
    for (k = 0; k < DEPTH - 7; k++)
      send_request(value_t'(int'(k % 5) * 3 - 6), 1'b0);
    // insert into full store, then close with full store
    send_request(MAX_VALUE, 1'b0);
    send_request(MIN_VALUE, 1'b1);

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 75)
        set_len = $urandom_range(1, DEPTH);
      else if (r < 90)
        set_len = DEPTH + $urandom_range(1, 4);
      else
        set_len = DEPTH;
      for (k = 1; k <= set_len; k++)
        send_request(pick_value(), k == set_len);
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    sample_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
